// ===== hw/rtl/ustcd_pkg.sv =====
// Shared constants for the Unix-seconds-to-calendar-date pipeline.
// Holds the reciprocal multipliers for the constant divisions and the month-start table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ustcd_pkg;

  // Days are split off as (ts >> 7) / 675, because 86400 = 128 * 675.
  // The quotient is exact for every 25-bit dividend when using the
  // multiplier below and a 35-bit right shift.
  localparam int unsigned TsLoBits   = 7;
  localparam int unsigned TsHiBits   = 25;
  localparam int unsigned DayDiv     = 675;
  localparam int unsigned DayRecip   = 50903317;
  localparam int unsigned DayRecipW  = 26;
  localparam int unsigned DayShift   = 35;
  localparam int unsigned DaysW      = 16;
  localparam int unsigned SodW       = 17;

  // Hour is (sod >> 4) / 225, because 3600 = 16 * 225.
  localparam int unsigned HourRecip  = 9321;
  localparam int unsigned HourShift  = 21;
  localparam int unsigned SecsPerHr  = 3600;
  localparam int unsigned RemHrW     = 12;

  // Minute is (seconds within the hour >> 2) / 15, because 60 = 4 * 15.
  localparam int unsigned MinRecip   = 1093;
  localparam int unsigned MinShift   = 14;
  localparam int unsigned SecsPerMin = 60;

  // The date is worked out in a calendar whose years start on 1 March,
  // counted from 1 March 1968, so that every leap day is the last day of
  // its year. The one missing leap day in range, 29 February 2100, is
  // put back by moving all later days one place on.
  localparam int unsigned EpochOffset = 671;
  localparam int unsigned Skip2100    = 48212;
  localparam int unsigned DaysPerCyc  = 1461;
  localparam int unsigned CycRecip    = 91868;
  localparam int unsigned CycShift    = 27;
  localparam int unsigned CycW        = 6;
  localparam int unsigned DaysPerYr   = 365;
  localparam int unsigned RemCycW     = 11;
  localparam int unsigned DoyW        = 9;

  // Month in the March-based year is (5 * doy + 2) / 153.
  localparam int unsigned MpRecip     = 3427;
  localparam int unsigned MpShift     = 19;
  localparam int unsigned BaseYear    = 1968;

  // First day of each month within a year that starts on 1 March.
  function automatic logic [DoyW-1:0] month_start(input logic [3:0] mp);
    logic [DoyW-1:0] res;
    unique case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ustcd_tod.sv =====
// Time-of-day stages: splits seconds within the day into hour, minute and second.
// Five register stages under a shared enable; depends on ustcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ustcd_tod (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ustcd_pkg::SodW-1:0] sod_i,
  output logic [4:0]               hour_o,
  output logic [5:0]               minute_o,
  output logic [5:0]               second_o
);
  import ustcd_pkg::*;

  // Stage 3
  logic [26:0]       hprod_d, hprod_q;
  logic [SodW-1:0]   sod3_q;
  // Stage 4
  logic [4:0]        hour_d, hour4_q;
  logic [RemHrW-1:0] remh_d, remh4_q;
  logic [SodW-1:0]   hsec;
  // Stage 5
  logic [20:0]       mprod_d, mprod_q;
  logic [4:0]        hour5_q;
  logic [RemHrW-1:0] remh5_q;
  // Stage 6
  logic [5:0]        min_d, min6_q, sec_d, sec6_q;
  logic [4:0]        hour6_q;
  logic [RemHrW-1:0] msec;
  // Stage 7
  logic [4:0]        hour_q;
  logic [5:0]        minute_q, second_q;

  assign hprod_d = 27'(sod_i[SodW-1:4]) * 27'(HourRecip);

  assign hour_d = hprod_q[HourShift +: 5];
  assign hsec   = SodW'(hour_d) * SodW'(SecsPerHr);
  assign remh_d = RemHrW'(sod3_q - hsec);

  assign mprod_d = 21'(remh4_q[RemHrW-1:2]) * 21'(MinRecip);

  assign min_d = mprod_q[MinShift +: 6];
  assign msec  = RemHrW'(min_d) * RemHrW'(SecsPerMin);
  assign sec_d = 6'(remh5_q - msec);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hprod_q  <= hprod_d;
      sod3_q   <= sod_i;
      hour4_q  <= hour_d;
      remh4_q  <= remh_d;
      mprod_q  <= mprod_d;
      hour5_q  <= hour4_q;
      remh5_q  <= remh4_q;
      min6_q   <= min_d;
      sec6_q   <= sec_d;
      hour6_q  <= hour5_q;
      hour_q   <= hour6_q;
      minute_q <= min6_q;
      second_q <= sec6_q;
    end
  end

  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ustcd_date.sv =====
// Date stages: turns a day count from 1 March 1968 into year, month and day.
// Five register stages under a shared enable; depends on ustcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ustcd_date (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [ustcd_pkg::DaysW-1:0] zday_i,
  output logic [11:0]                 year_o,
  output logic [3:0]                  month_o,
  output logic [4:0]                  day_o
);
  import ustcd_pkg::*;

  // Stage 3
  logic [32:0]        cprod_d, cprod_q;
  logic [DaysW-1:0]   zday3_q;
  // Stage 4
  logic [CycW-1:0]    cyc_d, cyc4_q;
  logic [RemCycW-1:0] rcyc_d, rcyc4_q;
  logic [DaysW-1:0]   cdays;
  // Stage 5
  logic [1:0]         yic_d, yic5_q;
  logic [DoyW-1:0]    doy_d, doy5_q;
  logic [CycW-1:0]    cyc5_q;
  logic [RemCycW-1:0] ydays;
  // Stage 6
  logic [22:0]        mpprod_d, mpprod_q;
  logic [10:0]        mpnum;
  logic [DoyW-1:0]    doy6_q;
  logic [CycW-1:0]    cyc6_q;
  logic [1:0]         yic6_q;
  // Stage 7
  logic [3:0]         mp;
  logic               jan_feb;
  logic [11:0]        year_d, year_q;
  logic [3:0]         month_d, month_q;
  logic [4:0]         day_d, day_q;

  assign cprod_d = 33'(zday_i) * 33'(CycRecip);

  assign cyc_d  = cprod_q[CycShift +: CycW];
  assign cdays  = DaysW'(cyc_d) * DaysW'(DaysPerCyc);
  assign rcyc_d = RemCycW'(zday3_q - cdays);

  // The last day of a four-year cycle is a leap day and stays in year three.
  always_comb begin
    priority if (rcyc4_q >= RemCycW'(3 * DaysPerYr)) begin
      yic_d = 2'd3;
    end else if (rcyc4_q >= RemCycW'(2 * DaysPerYr)) begin
      yic_d = 2'd2;
    end else if (rcyc4_q >= RemCycW'(DaysPerYr)) begin
      yic_d = 2'd1;
    end else begin
      yic_d = 2'd0;
    end
  end
  assign ydays = RemCycW'(yic_d) * RemCycW'(DaysPerYr);
  assign doy_d = DoyW'(rcyc4_q - ydays);

  assign mpnum    = 11'({doy5_q, 2'b00}) + 11'(doy5_q) + 11'd2;
  assign mpprod_d = 23'(mpnum) * 23'(MpRecip);

  assign mp      = mpprod_q[MpShift +: 4];
  assign jan_feb = (mp >= 4'd10);
  assign day_d   = 5'(doy6_q - month_start(mp) + 9'd1);
  assign month_d = jan_feb ? (mp - 4'd9) : (mp + 4'd3);
  assign year_d  = 12'(BaseYear) + 12'({cyc6_q, 2'b00}) + 12'(yic6_q) + 12'(jan_feb);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cprod_q  <= cprod_d;
      zday3_q  <= zday_i;
      cyc4_q   <= cyc_d;
      rcyc4_q  <= rcyc_d;
      yic5_q   <= yic_d;
      doy5_q   <= doy_d;
      cyc5_q   <= cyc4_q;
      mpprod_q <= mpprod_d;
      doy6_q   <= doy5_q;
      cyc6_q   <= cyc5_q;
      yic6_q   <= yic5_q;
      year_q   <= year_d;
      month_q  <= month_d;
      day_q    <= day_d;
    end
  end

  assign year_o  = year_q;
  assign month_o = month_q;
  assign day_o   = day_q;

endmodule

`default_nettype wire

// ===== hw/rtl/unix_seconds_to_calendar_date.sv =====
// Unix seconds to Gregorian UTC date and time, as a seven-stage pipeline.
// Throughput is one timestamp per cycle; every stage holds while a result is stalled.
// Reset clears only the stage valid bits; the data registers are not reset.
// Depends on ustcd_pkg, ustcd_tod and ustcd_date.
`timescale 1ns / 1ps
`default_nettype none

module unix_seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] timestamp_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);
  import ustcd_pkg::*;

  localparam int unsigned Stages = 7;

  // One valid bit per stage. The pipeline moves as a whole: it advances
  // unless a finished result sits in the last stage and is being stalled.
  // Empty stages are overwritten like the rest, so bubbles are never squeezed
  // out; they travel with the data to the output.
  logic [Stages-1:0] vld_d, vld_q;
  logic              en;

  // Stage 1: the day count is (ts >> 7) / 675, done as one multiplication
  // by a rounded-up reciprocal that is exact across the full input range.
  logic [TsHiBits-1:0]              tshi;
  logic [TsHiBits+DayRecipW-1:0]    dprod_d, dprod_q;
  logic [TsHiBits-1:0]              tshi_q;
  logic [TsLoBits-1:0]              tslo_q;

  // Stage 2: seconds within the day follow from the remainder of the
  // division, and the day count is moved onto the March-based calendar.
  logic [DaysW-1:0]    days;
  logic [TsHiBits-1:0] dmul;
  logic [9:0]          drem;
  logic [SodW-1:0]     sod_d, sod_q;
  logic [DaysW-1:0]    zbase, zday_d, zday_q;

  assign en      = !(vld_q[Stages-1] && stall_i);
  assign stall_o = !en;
  assign vld_d   = {vld_q[Stages-2:0], valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign tshi    = timestamp_i[31:TsLoBits];
  assign dprod_d = (TsHiBits+DayRecipW)'(tshi) * (TsHiBits+DayRecipW)'(DayRecip);

  assign days  = dprod_q[DayShift +: DaysW];
  assign dmul  = TsHiBits'(days) * TsHiBits'(DayDiv);
  assign drem  = 10'(tshi_q - dmul);
  assign sod_d = {drem, tslo_q};

  // From 1 March 2100 on, every day moves one place to stand in for the
  // leap day that this century year does not have.
  assign zbase  = days + DaysW'(EpochOffset);
  assign zday_d = zbase + DaysW'(zbase >= DaysW'(Skip2100));

  always_ff @(posedge clk_i) begin
    if (en) begin
      dprod_q <= dprod_d;
      tshi_q  <= tshi;
      tslo_q  <= timestamp_i[TsLoBits-1:0];
      sod_q   <= sod_d;
      zday_q  <= zday_d;
    end
  end

  // Stages 3 to 7 run side by side: time of day and calendar date.
  ustcd_tod u_tod (
    .clk_i    (clk_i),
    .en_i     (en),
    .sod_i    (sod_q),
    .hour_o   (hour_o),
    .minute_o (minute_o),
    .second_o (second_o)
  );

  ustcd_date u_date (
    .clk_i   (clk_i),
    .en_i    (en),
    .zday_i  (zday_q),
    .year_o  (year_o),
    .month_o (month_o),
    .day_o   (day_o)
  );

  assign valid_o = vld_q[Stages-1];

  // A stalled result freezes every stage, valid bits included.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved while the output was stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (year_o >= 12'd1970) && (year_o <= 12'd2106))
    else $error("year out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (month_o >= 4'd1) && (month_o <= 4'd12) && (day_o >= 5'd1))
    else $error("month or day out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (hour_o <= 5'd23) && (minute_o <= 6'd59) && (second_o <= 6'd59))
    else $error("time of day out of range");

endmodule

`default_nettype wire

// ===== verif/ustcd_date_checker.sv =====
// Checker for the Unix-seconds-to-calendar-date block: it predicts each date and compares.
// It watches both channels, keeps the expected dates in order and counts failures.
// Depends on nothing but the signals it is given.
`timescale 1ns / 1ps

module ustcd_date_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] ts_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam int unsigned SecsPerMin  = 60;
  localparam int unsigned EpochYear   = 1970;

  typedef struct packed {
    logic [31:0] ts;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  calendar_t expected_dates[$];
  int        fail_count = 0;

  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Exact day count: whole years are taken off from 1970, then whole months.
  function automatic calendar_t calendar_of_timestamp(input logic [31:0] ts);
    calendar_t   res;
    int unsigned secs;
    int unsigned day_left;
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    int unsigned year_len;
    secs     = ts;
    day_left = secs / SecsPerDay;
    sod      = secs % SecsPerDay;
    yr       = EpochYear;
    year_len = leap_year(yr) ? 366 : 365;
    while (day_left >= year_len) begin
      day_left -= year_len;
      yr++;
      year_len = leap_year(yr) ? 366 : 365;
    end
    mon = 1;
    while (mon < 12 && day_left >= days_in_month(mon, yr)) begin
      day_left -= days_in_month(mon, yr);
      mon++;
    end
    res.ts     = ts;
    res.year   = yr[11:0];
    res.month  = mon[3:0];
    res.day    = 5'(day_left + 1);
    res.hour   = 5'(sod / SecsPerHour);
    res.minute = 6'((sod % SecsPerHour) / SecsPerMin);
    res.second = 6'(sod % SecsPerMin);
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] ts,
                               input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s mismatch for timestamp %0d: expected %0d, got %0d", name, ts, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    calendar_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) expected_dates.push_back(calendar_of_timestamp(ts_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_dates.size() == 0) begin
          $error("result %0d-%0d-%0d %0d:%0d:%0d arrived with no transfer outstanding",
                 year_i, month_i, day_i, hour_i, minute_i, second_i);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          compare_field("year", want.ts, 32'(want.year), 32'(year_i));
          compare_field("month", want.ts, 32'(want.month), 32'(month_i));
          compare_field("day", want.ts, 32'(want.day), 32'(day_i));
          compare_field("hour", want.ts, 32'(want.hour), 32'(hour_i));
          compare_field("minute", want.ts, 32'(want.minute), 32'(minute_i));
          compare_field("second", want.ts, 32'(want.second), 32'(second_i));
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_dates.size();
  end

endmodule

// ===== verif/tb_unix_seconds_to_calendar_date.sv =====
// Testbench top for unix_seconds_to_calendar_date: clock, reset, stimulus and verdict.
// Prediction and comparison live in ustcd_date_checker, instantiated beside the block.
// Depends on unix_seconds_to_calendar_date and ustcd_date_checker.
`timescale 1ns / 1ps

module tb_unix_seconds_to_calendar_date;

  // Stimulus sizing. The directed list adds 23 items to the random ones.
  localparam int RandomItems = 1130;
  // The final stretch of the run is sent with neither side idling.
  localparam int QuietItems  = 150;
  // Watchdog limit in cycles, far above what the run needs even with both sides idling.
  localparam int CycleLimit  = 200000;
  // Extra wait after the last expected date, so that stray results can still show.
  localparam int DrainCycles = 12;

  // Day number of 1 March 2100, the day after the missing leap day.
  localparam longint Mar2100Day = 47541;
  localparam longint SecsPerDay = 86400;
  localparam longint TsMax      = 64'hFFFF_FFFF;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [31:0] timestamp_i;
  logic        valid_o;
  logic        stall_i;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  int fail_count;
  int pending;
  int cycle_count;
  bit quiet;

  unix_seconds_to_calendar_date u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (valid_i),
    .stall_o     (stall_o),
    .timestamp_i (timestamp_i),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .year_o      (year_o),
    .month_o     (month_o),
    .day_o       (day_o),
    .hour_o      (hour_o),
    .minute_o    (minute_o),
    .second_o    (second_o)
  );

  ustcd_date_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid_i),
    .in_stall_i   (stall_o),
    .ts_i         (timestamp_i),
    .out_valid_i  (valid_o),
    .out_stall_i  (stall_i),
    .year_i       (year_o),
    .month_i      (month_o),
    .day_i        (day_o),
    .hour_i       (hour_o),
    .minute_i     (minute_o),
    .second_i     (second_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 20 ns clock period.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Picks a random timestamp. Most picks are aimed at the places where a
  // date conversion tends to go wrong: midnight, New Year, the end of
  // February, the missing leap day of 2100 and both ends of the range.
  // The rest are fully random so that every bit of the timestamp toggles.
  function automatic logic [31:0] pick_timestamp();
    int unsigned kind;
    int unsigned yr;
    longint      day_num;
    longint      ts;
    kind = $urandom_range(0, 9);
    case (kind)
      4: begin
        // Just after or just before midnight on a random day.
        day_num = $urandom_range(0, 49709);
        ts = day_num * SecsPerDay;
        if ($urandom_range(0, 1) == 1) ts += $urandom_range(0, 3);
        else ts += SecsPerDay - 1 - $urandom_range(0, 3);
      end
      5, 6: begin
        // Around New Year or the end of February in a random year. The
        // year start counts leap years by fours and leaves out 2100.
        yr = $urandom_range(1971, 2106);
        day_num = (yr - 1970) * 365 + (yr - 1969) / 4 - ((yr > 2100) ? 1 : 0);
        if (kind == 6) day_num += $urandom_range(58, 60);
        ts = day_num * SecsPerDay + $urandom_range(0, 2 * SecsPerDay) - SecsPerDay;
      end
      7: ts = Mar2100Day * SecsPerDay + $urandom_range(0, 6 * SecsPerDay) - 3 * SecsPerDay;
      8: ts = TsMax - $urandom_range(0, 200000);
      9: ts = $urandom_range(0, 200000);
      default: ts = $urandom;
    endcase
    if (ts < 0) ts = 0;
    if (ts > TsMax) ts = TsMax;
    return ts[31:0];
  endfunction

  // Offers one timestamp and holds it until the block takes the transfer.
  // Valid stays high into the next item unless an idle burst comes first.
  task automatic send_timestamp(input logic [31:0] ts);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    valid_i     <= 1'b1;
    timestamp_i <= ts;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
  endtask

  // Receiver side: stalls the result channel in random bursts, with unstalled
  // stretches between, until the final stretch.
  initial begin
    stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if it never drains.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    // Directed cases: the ends of the range, the boundaries of each time
    // field, leap days in 1972 and 2000, and the end of February 2100,
    // which is not a leap year. The largest timestamp lands in 2106.
    logic [31:0] directed[$] = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd68169600, 32'd946684799, 32'd946684800,
      32'd951782400, 32'd978307199, 32'd2147483647, 32'd2147483648,
      32'd4107542399, 32'd4107542400, 32'd4133980799, 32'd4133980800,
      32'hFFFF_FFFE, 32'hFFFF_FFFF
    };
    int n;
    quiet       = 1'b0;
    rst_ni      <= 1'b0;
    valid_i     <= 1'b0;
    timestamp_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_timestamp(directed[k]);
    for (n = 0; n < RandomItems; n++) begin
      if (n >= RandomItems - QuietItems) quiet = 1'b1;
      send_timestamp(pick_timestamp());
    end
    valid_i <= 1'b0;

    // Wait for every outstanding date, then a few more cycles so that any
    // surplus result is caught by the checker before the verdict.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
